>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the shading pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

>>> hdl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Types, widths, register codes and helpers of the Phong shading pipeline.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int FRAC_BITS = 14;
    localparam int EXP_BITS  = 8;
    localparam int LANES     = 3;

    localparam int VEC_W  = 16;
    localparam int COL_W  = 16;
    localparam int GAIN_W = 16;
    localparam int OUT_W  = 16;
    localparam int CFG_W  = 16;

    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_SHININESS = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SPEC_GAIN = REG_IDX_W'(1);

    localparam logic [EXP_BITS-1:0] SHININESS_RST = EXP_BITS'(32);
    localparam logic [GAIN_W-1:0]   SPEC_GAIN_RST = GAIN_W'(8192);

    localparam int NP_W    = 2 * VEC_W;
    localparam int DOT1_W  = NP_W + 2;
    localparam int LN_W    = DOT1_W - FRAC_BITS;
    localparam int KD_W    = LN_W - 1;
    localparam int RN_W    = LN_W + VEC_W + 1;
    localparam int R_W     = RN_W - FRAC_BITS + 1;
    localparam int RD_P_W  = R_W + VEC_W;
    localparam int DOT2_W  = RD_P_W + 2;
    localparam int RD_W    = DOT2_W - FRAC_BITS;
    localparam int POW_W   = 31;
    localparam int CLAMP_W = (RD_W > POW_W) ? RD_W : POW_W;
    localparam int SG_W    = POW_W + GAIN_W - FRAC_BITS;
    localparam int SAT_IN_W = SG_W + COL_W - FRAC_BITS;

    localparam logic [POW_W-1:0] POW_SAT = '1;
    localparam logic [POW_W-1:0] POW_ONE = POW_W'(1) << FRAC_BITS;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam int GEOM_STAGES  = 6;
    localparam int COLOR_STAGES = 2;
    localparam int LATENCY      = GEOM_STAGES + EXP_BITS + COLOR_STAGES;

    typedef struct packed {
        logic signed [VEC_W-1:0] light_x;
        logic signed [VEC_W-1:0] light_y;
        logic signed [VEC_W-1:0] light_z;
        logic signed [VEC_W-1:0] normal_x;
        logic signed [VEC_W-1:0] normal_y;
        logic signed [VEC_W-1:0] normal_z;
        logic signed [VEC_W-1:0] ray_x;
        logic signed [VEC_W-1:0] ray_y;
        logic signed [VEC_W-1:0] ray_z;
        logic [COL_W-1:0]        color_r;
        logic [COL_W-1:0]        color_g;
        logic [COL_W-1:0]        color_b;
    } in_beat_t;

    typedef struct packed {
        logic [OUT_W-1:0] diffuse_r;
        logic [OUT_W-1:0] diffuse_g;
        logic [OUT_W-1:0] diffuse_b;
        logic [OUT_W-1:0] specular_r;
        logic [OUT_W-1:0] specular_g;
        logic [OUT_W-1:0] specular_b;
    } out_beat_t;

    // Color and finished diffuse terms carried alongside the power chain.
    typedef struct packed {
        logic [COL_W-1:0] color_r;
        logic [COL_W-1:0] color_g;
        logic [COL_W-1:0] color_b;
        logic [OUT_W-1:0] diffuse_r;
        logic [OUT_W-1:0] diffuse_g;
        logic [OUT_W-1:0] diffuse_b;
    } pass_t;

    function automatic logic [OUT_W-1:0] sat_out(input logic [SAT_IN_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > SAT_IN_W'(OUT_MAX))
        begin
            r = OUT_MAX;
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/pls_cfg_regs.sv
// ----------------------------------------------------------------------------
// pls_cfg_regs
// Shininess exponent and specular gain registers behind a plain write port.
// ----------------------------------------------------------------------------
module pls_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pls_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [pls_pkg::CFG_W-1:0]      cfg_data,
    output logic [pls_pkg::EXP_BITS-1:0]   shininess,
    output logic [pls_pkg::GAIN_W-1:0]     specular_gain
);

    logic [pls_pkg::EXP_BITS-1:0] shininess_reg;
    logic [pls_pkg::EXP_BITS-1:0] shininess_next;
    logic [pls_pkg::GAIN_W-1:0]   gain_reg;
    logic [pls_pkg::GAIN_W-1:0]   gain_next;

    always_comb
    begin
        shininess_next = shininess_reg;
        gain_next      = gain_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                pls_pkg::REG_SHININESS:
                begin
                    shininess_next = cfg_data[pls_pkg::EXP_BITS-1:0];
                end
                pls_pkg::REG_SPEC_GAIN:
                begin
                    gain_next = cfg_data[pls_pkg::GAIN_W-1:0];
                end
                default:
                begin
                    shininess_next = shininess_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shininess_reg <= pls_pkg::SHININESS_RST;
            gain_reg      <= pls_pkg::SPEC_GAIN_RST;
        end
        else
        begin
            shininess_reg <= shininess_next;
            gain_reg      <= gain_next;
        end
    end

    assign shininess     = shininess_reg;
    assign specular_gain = gain_reg;

endmodule

>>> hdl/pls_geom.sv
// ----------------------------------------------------------------------------
// pls_geom
// Six-stage front end: L.N, reflection vector, R.D, clamped power base and
// the finished diffuse terms.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pls_geom (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_in,
    input  pls_pkg::in_beat_t            operands,
    output logic                         valid_out,
    output logic [pls_pkg::POW_W-1:0]    base_out,
    output pls_pkg::pass_t               pass_out
);

    localparam int L = pls_pkg::LANES;

    logic signed [pls_pkg::VEC_W-1:0] l_in [L];
    logic signed [pls_pkg::VEC_W-1:0] n_in [L];
    logic signed [pls_pkg::VEC_W-1:0] d_in [L];
    logic [pls_pkg::COL_W-1:0]        c_in [L];

    logic [pls_pkg::GEOM_STAGES-1:0] valid_reg;

    // Stage 1: per-lane L*N.
    logic signed [pls_pkg::NP_W-1:0]  lnp_next [L];
    logic signed [pls_pkg::NP_W-1:0]  lnp_reg  [L];
    logic signed [pls_pkg::VEC_W-1:0] l1_reg   [L];
    logic signed [pls_pkg::VEC_W-1:0] n1_reg   [L];
    logic signed [pls_pkg::VEC_W-1:0] d1_reg   [L];
    logic [pls_pkg::COL_W-1:0]        c1_reg   [L];

    // Stage 2: ln.
    logic signed [pls_pkg::DOT1_W-1:0] dot1;
    logic signed [pls_pkg::LN_W-1:0]   ln_next;
    logic signed [pls_pkg::LN_W-1:0]   ln_reg;
    logic signed [pls_pkg::VEC_W-1:0]  l2_reg [L];
    logic signed [pls_pkg::VEC_W-1:0]  n2_reg [L];
    logic signed [pls_pkg::VEC_W-1:0]  d2_reg [L];
    logic [pls_pkg::COL_W-1:0]         c2_reg [L];

    // Stage 3: 2*ln*N and diffuse.
    logic signed [pls_pkg::RN_W-1:0]        rn_next [L];
    logic signed [pls_pkg::RN_W-1:0]        rn_reg  [L];
    logic [pls_pkg::KD_W-1:0]               kd;
    logic [pls_pkg::COL_W+pls_pkg::KD_W-1:0] dprod  [L];
    logic [pls_pkg::OUT_W-1:0]              diff_next [L];
    logic [pls_pkg::OUT_W-1:0]              diff3_reg [L];
    logic signed [pls_pkg::VEC_W-1:0]       l3_reg [L];
    logic signed [pls_pkg::VEC_W-1:0]       d3_reg [L];
    logic [pls_pkg::COL_W-1:0]              c3_reg [L];

    // Stage 4: reflection vector.
    logic signed [pls_pkg::R_W-1:0]   r_next [L];
    logic signed [pls_pkg::R_W-1:0]   r_reg  [L];
    logic [pls_pkg::OUT_W-1:0]        diff4_reg [L];
    logic signed [pls_pkg::VEC_W-1:0] d4_reg [L];
    logic [pls_pkg::COL_W-1:0]        c4_reg [L];

    // Stage 5: per-lane R*D.
    logic signed [pls_pkg::RD_P_W-1:0] rdp_next [L];
    logic signed [pls_pkg::RD_P_W-1:0] rdp_reg  [L];
    logic [pls_pkg::OUT_W-1:0]         diff5_reg [L];
    logic [pls_pkg::COL_W-1:0]         c5_reg [L];

    // Stage 6: rd and the clamped base.
    logic signed [pls_pkg::DOT2_W-1:0] dot2;
    logic signed [pls_pkg::RD_W-1:0]   rd;
    logic [pls_pkg::CLAMP_W-1:0]       rd_wide;
    logic [pls_pkg::POW_W-1:0]         base_next;
    logic [pls_pkg::POW_W-1:0]         base_reg;
    logic [pls_pkg::OUT_W-1:0]         diff6_reg [L];
    logic [pls_pkg::COL_W-1:0]         c6_reg [L];

    always_comb
    begin
        l_in[0] = operands.light_x;
        l_in[1] = operands.light_y;
        l_in[2] = operands.light_z;
        n_in[0] = operands.normal_x;
        n_in[1] = operands.normal_y;
        n_in[2] = operands.normal_z;
        d_in[0] = operands.ray_x;
        d_in[1] = operands.ray_y;
        d_in[2] = operands.ray_z;
        c_in[0] = operands.color_r;
        c_in[1] = operands.color_g;
        c_in[2] = operands.color_b;
    end

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            lnp_next[i] = l_in[i] * n_in[i];
        end
    end

    always_comb
    begin
        dot1 = pls_pkg::DOT1_W'(lnp_reg[0]) + pls_pkg::DOT1_W'(lnp_reg[1])
             + pls_pkg::DOT1_W'(lnp_reg[2]);
        ln_next = $signed(dot1[pls_pkg::DOT1_W-1:pls_pkg::FRAC_BITS]);
    end

    always_comb
    begin
        kd = ln_reg[pls_pkg::LN_W-1] ? '0 : ln_reg[pls_pkg::KD_W-1:0];
        for (int i = 0; i < L; i++)
        begin
            rn_next[i]   = (ln_reg * n2_reg[i]) <<< 1;
            dprod[i]     = c2_reg[i] * kd;
            diff_next[i] = pls_pkg::sat_out(pls_pkg::SAT_IN_W'(
                dprod[i][pls_pkg::COL_W+pls_pkg::KD_W-1:pls_pkg::FRAC_BITS]));
        end
    end

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            r_next[i] = pls_pkg::R_W'(l3_reg[i])
                      - pls_pkg::R_W'($signed(rn_reg[i][pls_pkg::RN_W-1:pls_pkg::FRAC_BITS]));
            rdp_next[i] = r_reg[i] * d4_reg[i];
        end
    end

    always_comb
    begin
        dot2 = pls_pkg::DOT2_W'(rdp_reg[0]) + pls_pkg::DOT2_W'(rdp_reg[1])
             + pls_pkg::DOT2_W'(rdp_reg[2]);
        rd = $signed(dot2[pls_pkg::DOT2_W-1:pls_pkg::FRAC_BITS]);
        rd_wide = pls_pkg::CLAMP_W'(rd);
        if (rd[pls_pkg::RD_W-1])
        begin
            base_next = '0;
        end
        else if (rd_wide > pls_pkg::CLAMP_W'(pls_pkg::POW_SAT))
        begin
            base_next = pls_pkg::POW_SAT;
        end
        else
        begin
            base_next = rd_wide[pls_pkg::POW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[pls_pkg::GEOM_STAGES-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < L; i++)
        begin
            lnp_reg[i]   <= lnp_next[i];
            l1_reg[i]    <= l_in[i];
            n1_reg[i]    <= n_in[i];
            d1_reg[i]    <= d_in[i];
            c1_reg[i]    <= c_in[i];
            l2_reg[i]    <= l1_reg[i];
            n2_reg[i]    <= n1_reg[i];
            d2_reg[i]    <= d1_reg[i];
            c2_reg[i]    <= c1_reg[i];
            rn_reg[i]    <= rn_next[i];
            diff3_reg[i] <= diff_next[i];
            l3_reg[i]    <= l2_reg[i];
            d3_reg[i]    <= d2_reg[i];
            c3_reg[i]    <= c2_reg[i];
            r_reg[i]     <= r_next[i];
            diff4_reg[i] <= diff3_reg[i];
            d4_reg[i]    <= d3_reg[i];
            c4_reg[i]    <= c3_reg[i];
            rdp_reg[i]   <= rdp_next[i];
            diff5_reg[i] <= diff4_reg[i];
            c5_reg[i]    <= c4_reg[i];
            diff6_reg[i] <= diff5_reg[i];
            c6_reg[i]    <= c5_reg[i];
        end
        ln_reg   <= ln_next;
        base_reg <= base_next;
    end

    assign valid_out          = valid_reg[pls_pkg::GEOM_STAGES-1];
    assign base_out           = base_reg;
    assign pass_out.color_r   = c6_reg[0];
    assign pass_out.color_g   = c6_reg[1];
    assign pass_out.color_b   = c6_reg[2];
    assign pass_out.diffuse_r = diff6_reg[0];
    assign pass_out.diffuse_g = diff6_reg[1];
    assign pass_out.diffuse_b = diff6_reg[2];

    // A light facing away from the surface leaves no diffuse light.
    `ASSERT_NEXT(a_facing_away, clk, rst_n, valid_reg[1] && ln_reg[pls_pkg::LN_W-1],
        diff3_reg[0] == '0 && diff3_reg[1] == '0 && diff3_reg[2] == '0)

endmodule

>>> hdl/pls_pow_stage.sv
// ----------------------------------------------------------------------------
// pls_pow_stage
// One square-and-multiply step of the shininess power, with saturation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pls_pow_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       valid_in,
    input  logic                       exp_bit,
    input  logic [pls_pkg::POW_W-1:0]  pw_in,
    input  logic [pls_pkg::POW_W-1:0]  base_in,
    input  pls_pkg::pass_t             pass_in,
    output logic                       valid_out,
    output logic [pls_pkg::POW_W-1:0]  pw_out,
    output logic [pls_pkg::POW_W-1:0]  base_out,
    output pls_pkg::pass_t             pass_out
);

    localparam int PROD_W = 2 * pls_pkg::POW_W;
    localparam int SHR_W  = PROD_W - pls_pkg::FRAC_BITS;

    logic [PROD_W-1:0]          mul_prod;
    logic [PROD_W-1:0]          sq_prod;
    logic [SHR_W-1:0]           mul_shr;
    logic [SHR_W-1:0]           sq_shr;
    logic [pls_pkg::POW_W-1:0]  pw_next;
    logic [pls_pkg::POW_W-1:0]  base_next;
    logic                       valid_reg;
    logic [pls_pkg::POW_W-1:0]  pw_reg;
    logic [pls_pkg::POW_W-1:0]  base_reg;
    pls_pkg::pass_t             pass_reg;

    always_comb
    begin
        mul_prod = pw_in * base_in;
        sq_prod  = base_in * base_in;
        mul_shr  = mul_prod[PROD_W-1:pls_pkg::FRAC_BITS];
        sq_shr   = sq_prod[PROD_W-1:pls_pkg::FRAC_BITS];
        if (!exp_bit)
        begin
            pw_next = pw_in;
        end
        else if (mul_shr > SHR_W'(pls_pkg::POW_SAT))
        begin
            pw_next = pls_pkg::POW_SAT;
        end
        else
        begin
            pw_next = mul_shr[pls_pkg::POW_W-1:0];
        end
        if (sq_shr > SHR_W'(pls_pkg::POW_SAT))
        begin
            base_next = pls_pkg::POW_SAT;
        end
        else
        begin
            base_next = sq_shr[pls_pkg::POW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg   <= pw_next;
        base_reg <= base_next;
        pass_reg <= pass_in;
    end

    assign valid_out = valid_reg;
    assign pw_out    = pw_reg;
    assign base_out  = base_reg;
    assign pass_out  = pass_reg;

    // A clear exponent bit passes the running power through untouched.
    `ASSERT_NEXT(a_pw_hold, clk, rst_n, valid_in && !exp_bit, pw_reg == $past(pw_in))

endmodule

>>> hdl/pls_color.sv
// ----------------------------------------------------------------------------
// pls_color
// Two-stage back end: power times specular gain, then times each color,
// saturated and merged with the diffuse terms into the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pls_color (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid_in,
    input  logic [pls_pkg::POW_W-1:0]   pw_in,
    input  pls_pkg::pass_t              pass_in,
    input  logic [pls_pkg::GAIN_W-1:0]  specular_gain,
    output logic                        done,
    output pls_pkg::out_beat_t          result
);

    localparam int SGP_W = pls_pkg::POW_W + pls_pkg::GAIN_W;
    localparam int SPP_W = pls_pkg::SG_W + pls_pkg::COL_W;

    logic [pls_pkg::COLOR_STAGES-1:0] valid_reg;
    logic [SGP_W-1:0]                 sg_prod;
    logic [pls_pkg::SG_W-1:0]         sg_reg;
    pls_pkg::pass_t                   pass_reg;
    logic [SPP_W-1:0]                 spp_r;
    logic [SPP_W-1:0]                 spp_g;
    logic [SPP_W-1:0]                 spp_b;
    pls_pkg::out_beat_t               result_next;
    pls_pkg::out_beat_t               result_reg;

    always_comb
    begin
        sg_prod = pw_in * specular_gain;
        spp_r   = sg_reg * pass_reg.color_r;
        spp_g   = sg_reg * pass_reg.color_g;
        spp_b   = sg_reg * pass_reg.color_b;
        result_next.diffuse_r  = pass_reg.diffuse_r;
        result_next.diffuse_g  = pass_reg.diffuse_g;
        result_next.diffuse_b  = pass_reg.diffuse_b;
        result_next.specular_r = pls_pkg::sat_out(spp_r[SPP_W-1:pls_pkg::FRAC_BITS]);
        result_next.specular_g = pls_pkg::sat_out(spp_g[SPP_W-1:pls_pkg::FRAC_BITS]);
        result_next.specular_b = pls_pkg::sat_out(spp_b[SPP_W-1:pls_pkg::FRAC_BITS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[pls_pkg::COLOR_STAGES-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        sg_reg     <= sg_prod[SGP_W-1:pls_pkg::FRAC_BITS];
        pass_reg   <= pass_in;
        result_reg <= result_next;
    end

    assign done   = valid_reg[pls_pkg::COLOR_STAGES-1];
    assign result = result_reg;

    // No specular light leaves the block once the scaled power is zero.
    `ASSERT_NEXT(a_zero_specular, clk, rst_n, valid_reg[0] && sg_reg == '0,
        result_reg.specular_r == '0 && result_reg.specular_g == '0 &&
        result_reg.specular_b == '0)

endmodule

>>> hdl/phong_light_shading.sv
// ----------------------------------------------------------------------------
// phong_light_shading
// Per-light Phong diffuse and specular shading of one hit point, pipelined.
// ----------------------------------------------------------------------------
// A beat enters on start; busy stays low, so a new beat can enter in every
// cycle. The beat carries light direction, normal, ray direction and light
// color; vectors are signed Q2.14, color is unsigned Q2.14. Each beat gives
// exactly one result beat on result, marked by done for a single cycle.
// The pipeline is six stages of vector math, one stage per shininess bit of
// the square-and-multiply chain (eight), and two stages of color scaling.
// Throughput is one beat per cycle; the receiver cannot stall, and results
// are never held back.
// Shininess and specular gain are written through cfg_we, cfg_index and
// cfg_data; index 0 is shininess and index 1 is specular gain. Writes take
// effect at once and belong in idle periods.
// Reset clears every valid bit and loads shininess 32 and gain 0.5.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module phong_light_shading (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pls_pkg::in_beat_t              operands,
    output logic                           done,
    output pls_pkg::out_beat_t             result,
    input  logic                           cfg_we,
    input  logic [pls_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [pls_pkg::CFG_W-1:0]      cfg_data
);

    localparam int E = pls_pkg::EXP_BITS;

    logic [E-1:0]                shininess;
    logic [pls_pkg::GAIN_W-1:0]  specular_gain;
    logic                        valid_chain [E+1];
    logic [pls_pkg::POW_W-1:0]   pw_chain    [E+1];
    logic [pls_pkg::POW_W-1:0]   base_chain  [E+1];
    pls_pkg::pass_t              pass_chain  [E+1];

    assign busy        = 1'b0;
    assign pw_chain[0] = pls_pkg::POW_ONE;

    pls_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .shininess     (shininess),
        .specular_gain (specular_gain)
    );

    pls_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start && !busy),
        .operands  (operands),
        .valid_out (valid_chain[0]),
        .base_out  (base_chain[0]),
        .pass_out  (pass_chain[0])
    );

    for (genvar k = 0; k < E; k++)
    begin : g_pow
        pls_pow_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[k]),
            .exp_bit   (shininess[k]),
            .pw_in     (pw_chain[k]),
            .base_in   (base_chain[k]),
            .pass_in   (pass_chain[k]),
            .valid_out (valid_chain[k+1]),
            .pw_out    (pw_chain[k+1]),
            .base_out  (base_chain[k+1]),
            .pass_out  (pass_chain[k+1])
        );
    end

    pls_color u_color (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid_in      (valid_chain[E] && (base_chain[E] == base_chain[E])),
        .pw_in         (pw_chain[E]),
        .pass_in       (pass_chain[E]),
        .specular_gain (specular_gain),
        .done          (done),
        .result        (result)
    );

    // Every result beat goes back to an earlier accepted start.
    `ASSERT_SAME(a_done_latency, clk, rst_n, done, $past(start, pls_pkg::LATENCY))

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for phong_light_shading. Lighting beats are driven
// through the start/busy handshake and each one is shaded by an in-bench
// fixed point model of the diffuse and specular terms. Every result beat
// is checked field by field against the oldest expected beat. A directed
// part covers the field extremes, lights and reflections facing away, a
// zero exponent and a saturated power. Register sweeps and a long random
// stream with idle bursts follow.
// ----------------------------------------------------------------------------

module tb;

    localparam int FRAC = 14;
    localparam int EXP_LEN = 8;
    localparam longint unsigned POW_LIMIT = 64'h7FFF_FFFF;
    localparam longint unsigned SHADE_MAX = 64'hFFFF;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT = 300000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    pls_pkg::in_beat_t operands = '0;
    logic done;
    pls_pkg::out_beat_t result;
    logic cfg_we = 1'b0;
    logic [pls_pkg::REG_IDX_W-1:0] cfg_index = pls_pkg::REG_SHININESS;
    logic [pls_pkg::CFG_W-1:0] cfg_data = '0;

    logic [7:0] shininess_now = 8'd32;
    logic [15:0] spec_gain_now = 16'd8192;

    pls_pkg::out_beat_t shade_queue[$];
    pls_pkg::out_beat_t want;
    int mismatch_count = 0;
    int cycle_count = 0;

    phong_light_shading DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operands(operands),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void reflect_light(input pls_pkg::in_beat_t b, output longint ln,
                                          output longint refl [3]);
        longint lv [3];
        longint nv [3];
        lv[0] = longint'($signed(b.light_x));
        lv[1] = longint'($signed(b.light_y));
        lv[2] = longint'($signed(b.light_z));
        nv[0] = longint'($signed(b.normal_x));
        nv[1] = longint'($signed(b.normal_y));
        nv[2] = longint'($signed(b.normal_z));
        ln = (lv[0] * nv[0] + lv[1] * nv[1] + lv[2] * nv[2]) >>> FRAC;
        for (int i = 0; i < 3; i++)
        begin
            refl[i] = lv[i] - ((2 * ln * nv[i]) >>> FRAC);
        end
    endfunction

    function automatic longint unsigned pow_product(input longint unsigned a,
                                                    input longint unsigned b);
        longint unsigned p;
        p = (a * b) >> FRAC;
        return (p > POW_LIMIT) ? POW_LIMIT : p;
    endfunction

    function automatic logic [15:0] clip_shade(input longint unsigned v);
        return (v > SHADE_MAX) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic pls_pkg::out_beat_t shade_beat(input pls_pkg::in_beat_t b);
        longint ln;
        longint rd;
        longint refl [3];
        longint unsigned kd;
        longint unsigned base;
        longint unsigned pw;
        longint unsigned sg;
        pls_pkg::out_beat_t o;
        reflect_light(b, ln, refl);
        rd = (refl[0] * longint'($signed(b.ray_x)) + refl[1] * longint'($signed(b.ray_y))
              + refl[2] * longint'($signed(b.ray_z))) >>> FRAC;
        kd = 0;
        if (ln > 0)
        begin
            kd = longint'(ln);
        end
        base = 0;
        if (rd > 0)
        begin
            base = longint'(rd);
        end
        if (base > POW_LIMIT)
        begin
            base = POW_LIMIT;
        end
        pw = 64'd1 << FRAC;
        for (int i = 0; i < EXP_LEN; i++)
        begin
            if (shininess_now[i])
            begin
                pw = pow_product(pw, base);
            end
            base = pow_product(base, base);
        end
        sg = (pw * 64'(spec_gain_now)) >> FRAC;
        o.diffuse_r = clip_shade((64'(b.color_r) * kd) >> FRAC);
        o.diffuse_g = clip_shade((64'(b.color_g) * kd) >> FRAC);
        o.diffuse_b = clip_shade((64'(b.color_b) * kd) >> FRAC);
        o.specular_r = clip_shade((sg * 64'(b.color_r)) >> FRAC);
        o.specular_g = clip_shade((sg * 64'(b.color_g)) >> FRAC);
        o.specular_b = clip_shade((sg * 64'(b.color_b)) >> FRAC);
        return o;
    endfunction

    function automatic pls_pkg::in_beat_t make_beat(
        input int lx, input int ly, input int lz,
        input int nx, input int ny, input int nz,
        input int dx, input int dy, input int dz,
        input int cr, input int cg, input int cb);
        pls_pkg::in_beat_t b;
        b.light_x = 16'(lx);
        b.light_y = 16'(ly);
        b.light_z = 16'(lz);
        b.normal_x = 16'(nx);
        b.normal_y = 16'(ny);
        b.normal_z = 16'(nz);
        b.ray_x = 16'(dx);
        b.ray_y = 16'(dy);
        b.ray_z = 16'(dz);
        b.color_r = 16'(cr);
        b.color_g = 16'(cg);
        b.color_b = 16'(cb);
        return b;
    endfunction

    function automatic logic [15:0] clamp_vec(input longint v);
        if (v > 32767)
        begin
            return 16'h7FFF;
        end
        if (v < -32768)
        begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic logic [15:0] corner_value();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'hC000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h4000;
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic longint near_unit();
        return longint'($urandom_range(0, 18918)) - 9459;
    endfunction

    function automatic pls_pkg::in_beat_t random_beat();
        pls_pkg::in_beat_t b;
        longint ln;
        longint refl [3];
        longint sgn;
        int pick;
        b = pls_pkg::in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom});
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            b.light_x = 16'(near_unit());
            b.light_y = 16'(near_unit());
            b.light_z = 16'(near_unit());
            b.normal_x = 16'(near_unit());
            b.normal_y = 16'(near_unit());
            b.normal_z = 16'(near_unit());
            reflect_light(b, ln, refl);
            sgn = ($urandom_range(0, 3) == 0) ? -1 : 1;
            b.ray_x = clamp_vec(sgn * refl[0] + longint'($urandom_range(0, 1200)) - 600);
            b.ray_y = clamp_vec(sgn * refl[1] + longint'($urandom_range(0, 1200)) - 600);
            b.ray_z = clamp_vec(sgn * refl[2] + longint'($urandom_range(0, 1200)) - 600);
        end
        else if (pick < 8)
        begin
            b.light_x = corner_value();
            b.light_y = corner_value();
            b.light_z = corner_value();
            b.normal_x = corner_value();
            b.normal_y = corner_value();
            b.normal_z = corner_value();
            b.ray_x = corner_value();
            b.ray_y = corner_value();
            b.ray_z = corner_value();
            b.color_r = corner_value();
            b.color_g = corner_value();
            b.color_b = corner_value();
        end
        return b;
    endfunction

    task automatic send_beat(input pls_pkg::in_beat_t b);
        bit taken;
        taken = 1'b0;
        @(negedge clk);
        start <= 1'b1;
        operands <= b;
        while (!taken)
        begin
            @(posedge clk);
            if (!busy)
            begin
                taken = 1'b1;
                shade_queue.push_back(shade_beat(b));
            end
        end
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (shade_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pls_pkg::REG_IDX_W-1:0] idx,
                             input logic [pls_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx == pls_pkg::REG_SHININESS)
        begin
            shininess_now = value[7:0];
        end
        else
        begin
            spec_gain_now = value;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_lighting(input int shin, input int gain);
        write_reg(pls_pkg::REG_SHININESS, 16'(shin));
        write_reg(pls_pkg::REG_SPEC_GAIN, 16'(gain));
    endtask

    task automatic report_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (shade_queue.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat expected none, got %h", $time, result);
            end
            else
            begin
                want = shade_queue.pop_front();
                report_field("diffuse_r", want.diffuse_r, result.diffuse_r);
                report_field("diffuse_g", want.diffuse_g, result.diffuse_g);
                report_field("diffuse_b", want.diffuse_b, result.diffuse_b);
                report_field("specular_r", want.specular_r, result.specular_r);
                report_field("specular_g", want.specular_g, result.specular_g);
                report_field("specular_b", want.specular_b, result.specular_b);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_key_cases();
        send_beat(make_beat(16384, 0, 0, 16384, 0, 0, -16384, 0, 0, 16384, 16384, 16384));
        send_beat(make_beat(16384, 0, 0, 16384, 0, 0, 16384, 0, 0, 30000, 65535, 1));
        send_beat(make_beat(11585, 11585, 0, 0, 16384, 0, 11585, -11585, 0,
                            65535, 40000, 16384));
        send_beat(make_beat(32767, 32767, 32767, 32767, 32767, 32767,
                            -32768, -32768, -32768, 65535, 65535, 65535));
    endtask

    task automatic test_reset_defaults();
        send_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 65535, 65535, 65535));
        send_key_cases();
        send_beat(make_beat(-16384, 0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 8192, 65535));
        send_beat(make_beat(-32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768, 65535, 0, 65535));
        send_beat(make_beat(32767, -32768, 0, -32768, 32767, 1, -1, 32767, -32768,
                            1, 65535, 0));
        send_beat(make_beat(8000, -3000, 12000, 5000, 9000, -2000, -7000, 4000, 15000,
                            12345, 54321, 1));
        send_beat(make_beat(11585, 11585, 0, 0, 16384, 0, 11585, -11585, 0, 0, 0, 0));
        settle();
    endtask

    task automatic test_register_extremes();
        set_lighting(0, 16384);
        send_key_cases();
        settle();
        set_lighting(255, 65535);
        send_key_cases();
        settle();
        set_lighting(1, 0);
        send_key_cases();
        settle();
        set_lighting(128, 1);
        send_key_cases();
        settle();
    endtask

    task automatic test_random_stream();
        int shin;
        int gain;
        bit quiet;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    shin = 32;
                    gain = 8192;
                end
                1:
                begin
                    shin = $urandom_range(0, 255);
                    gain = $urandom_range(0, 65535);
                end
                2:
                begin
                    shin = 255;
                    gain = 65535;
                end
                3:
                begin
                    shin = 1;
                    gain = 16384;
                end
                default:
                begin
                    shin = $urandom_range(2, 16);
                    gain = $urandom_range(0, 65535);
                end
            endcase
            set_lighting(shin, gain);
            for (int k = 0; k < 400; k++)
            begin
                send_beat(random_beat());
                quiet = (phase == 4) || (k % 100 < 30);
                if (!quiet && $urandom_range(0, 5) == 0)
                begin
                    hold_off($urandom_range(1, 13));
                end
            end
            settle();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_random_stream();
        if (mismatch_count == 0 && shade_queue.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
